// ===== hw/rtl/igroc_pkg.sv =====
package igroc_pkg;

  // Widths fixed by the field formats.
  localparam int SPEED_W      = 24;
  localparam int NORM_W       = 32;
  localparam int RATE_W       = 32;
  localparam int TABLE_W      = 48;
  localparam int ENTRY_W      = 8;
  localparam int GAIN_W       = 16;  // interpolated gain in tenths, Q8.8
  localparam int DIFF_W       = 25;  // signed speed difference, Q16.8
  localparam int NUM_W        = 40;  // magnitude of gain times difference
  localparam int DEN_W        = 35;  // ten times the normaliser magnitude
  localparam int DIV_STEPS    = 32;  // one quotient bit per divider stage

  localparam int BREAKPOINTS_DEFAULT = 6;

  localparam logic [TABLE_W-1:0] GAIN_RESET = 48'h1919_1919_1919;
  localparam logic [RATE_W-1:0]  RATE_MAX   = 32'hFFFF_FFFF;

  // One stage of the restoring divider, with the bypass result carried along.
  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [RATE_W-1:0] low;
    logic [RATE_W-1:0] quo;
    logic              byp;
    logic [RATE_W-1:0] byp_rate;
    logic              byp_sat;
  } div_stage_t;

  // Table entry k; entries beyond the top of the register read as zero.
  function automatic logic [ENTRY_W-1:0] gain_entry(input logic [TABLE_W-1:0] tbl,
                                                    input logic [2:0] k);
    logic [63:0] ext;
    ext = {16'h0000, tbl};
    return ext[{k, 3'b000} +: ENTRY_W];
  endfunction

endpackage

// ===== hw/rtl/interp_gain_rate_of_change.sv =====
// Pipeline: table interpolation, numerator product, divider head, divider stages, result register.
// Throughput: one beat per cycle; the 32-stage restoring divider (one quotient bit per
// stage) sets the depth, and every stage holds while a result beat is stalled.
// Reset (synchronous, active high) empties every stage and loads the gain table with
// 0x191919191919 (every entry 2.5).
module interp_gain_rate_of_change #(
  parameter int BREAKPOINTS = igroc_pkg::BREAKPOINTS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [igroc_pkg::TABLE_W-1:0]    cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [igroc_pkg::SPEED_W-1:0]    engine_speed,
  input  logic [igroc_pkg::SPEED_W-1:0]    earlier_speed,
  input  logic [igroc_pkg::SPEED_W-1:0]    later_speed,
  input  logic signed [igroc_pkg::NORM_W-1:0] normaliser,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [igroc_pkg::RATE_W-1:0]     rate,
  output logic                             saturated
);
  import igroc_pkg::*;

  logic en;

  // The whole pipeline moves unless the result register holds a stalled beat.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Gain table register.
  logic [TABLE_W-1:0] gain_table;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_table <= GAIN_RESET;
    end else if (cfg_we) begin
      gain_table <= cfg_wdata;
    end
  end

  // Stage 1: table interpolation, speed difference and normaliser magnitude.
  logic [15:0]              ip;
  logic [ENTRY_W-1:0]       frac;
  logic [2:0]               idx_lo;
  logic [ENTRY_W-1:0]       ent_lo;
  logic [ENTRY_W-1:0]       ent_hi;
  logic [ENTRY_W-1:0]       ent_first;
  logic [ENTRY_W-1:0]       ent_last;
  logic signed [8:0]        slope;
  logic signed [17:0]       step_prod;
  logic signed [17:0]       interp;
  logic [GAIN_W-1:0]        gain_next;
  logic signed [DIFF_W-1:0] diff_next;
  logic [NORM_W-1:0]        den_mag_next;

  assign ip        = engine_speed[SPEED_W-1:8];
  assign frac      = engine_speed[7:0];
  assign idx_lo    = ip[2:0] - 3'd1;
  assign ent_lo    = gain_entry(gain_table, idx_lo);
  assign ent_hi    = gain_entry(gain_table, ip[2:0]);
  assign ent_first = gain_entry(gain_table, 3'd0);
  assign ent_last  = gain_entry(gain_table, 3'(BREAKPOINTS - 1));
  assign slope     = $signed({1'b0, ent_hi}) - $signed({1'b0, ent_lo});
  assign step_prod = $signed({1'b0, frac}) * slope;
  assign interp    = $signed({2'b00, ent_lo, 8'h00}) + step_prod;

  always_comb begin
    if (ip == 16'd0) begin
      gain_next = {ent_first, 8'h00};
    end else if (ip >= 16'(BREAKPOINTS)) begin
      gain_next = {ent_last, 8'h00};
    end else begin
      gain_next = interp[GAIN_W-1:0];
    end
  end

  assign diff_next    = $signed({1'b0, later_speed}) - $signed({1'b0, earlier_speed});
  assign den_mag_next = normaliser[NORM_W-1] ? (~normaliser + 32'd1) : normaliser;

  logic                     v1;
  logic [GAIN_W-1:0]        gain1;
  logic signed [DIFF_W-1:0] diff1;
  logic [NORM_W-1:0]        den_mag1;
  logic                     den_neg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gain1    <= gain_next;
      diff1    <= diff_next;
      den_mag1 <= den_mag_next;
      den_neg1 <= normaliser[NORM_W-1];
    end
  end

  // Stage 2: numerator product and ten times the divisor.
  logic signed [41:0] num_full;
  logic               num_neg_next;
  logic [41:0]        num_abs;
  logic [DEN_W-1:0]   den10_next;

  assign num_full     = $signed({1'b0, gain1}) * diff1;
  assign num_neg_next = num_full[41];
  assign num_abs      = num_neg_next ? 42'(-num_full) : 42'(num_full);
  assign den10_next   = (DEN_W'(den_mag1) << 3) + (DEN_W'(den_mag1) << 1);

  logic             v2;
  logic [NUM_W-1:0] num_mag2;
  logic             num_neg2;
  logic [DEN_W-1:0] den10_2;
  logic             den_neg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_mag2 <= num_abs[NUM_W-1:0];
      num_neg2 <= num_neg_next;
      den10_2  <= den10_next;
      den_neg2 <= den_neg1;
    end
  end

  // Stage 3: special cases and overflow check; loads the divider head.
  logic den_zero;
  logic num_zero;
  logic same_sign;
  logic ovf;

  assign den_zero  = (den10_2 == '0);
  assign num_zero  = (num_mag2 == '0);
  assign same_sign = (num_neg2 == den_neg2);
  // The quotient reaches 2^32 exactly when the numerator reaches divisor * 2^16.
  assign ovf       = ({11'd0, num_mag2} >= {den10_2, 16'h0000});

  div_stage_t            dstage [DIV_STEPS+1];
  logic [DIV_STEPS:0]    dv;
  div_stage_t            head_next;

  always_comb begin
    head_next.rem      = DEN_W'(num_mag2[NUM_W-1:16]);
    head_next.den      = den10_2;
    head_next.low      = {num_mag2[15:0], 16'h0000};
    head_next.quo      = '0;
    head_next.byp      = 1'b1;
    head_next.byp_rate = '0;
    head_next.byp_sat  = 1'b0;
    if (den_zero) begin
      head_next.byp_sat  = 1'b1;
      head_next.byp_rate = (!num_zero && !num_neg2) ? RATE_MAX : '0;
    end else if (num_zero || !same_sign) begin
      head_next.byp_rate = '0;
    end else if (ovf) begin
      head_next.byp_rate = RATE_MAX;
      head_next.byp_sat  = 1'b1;
    end else begin
      head_next.byp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dstage[0] <= head_next;
    end
  end

  // Divider stages: each takes one numerator bit and yields one quotient bit.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    logic [DEN_W:0] trial;
    logic [DEN_W:0] trial_sub;
    logic           fits;

    assign trial     = {dstage[s].rem, dstage[s].low[RATE_W-1]};
    assign trial_sub = trial - {1'b0, dstage[s].den};
    assign fits      = (trial >= {1'b0, dstage[s].den});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else if (en) begin
        dv[s+1] <= dv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dstage[s+1].rem      <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        dstage[s+1].den      <= dstage[s].den;
        dstage[s+1].low      <= {dstage[s].low[RATE_W-2:0], 1'b0};
        dstage[s+1].quo      <= {dstage[s].quo[RATE_W-2:0], fits};
        dstage[s+1].byp      <= dstage[s].byp;
        dstage[s+1].byp_rate <= dstage[s].byp_rate;
        dstage[s+1].byp_sat  <= dstage[s].byp_sat;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rate      <= dstage[DIV_STEPS].byp ? dstage[DIV_STEPS].byp_rate
                                         : dstage[DIV_STEPS].quo;
      saturated <= dstage[DIV_STEPS].byp && dstage[DIV_STEPS].byp_sat;
    end
  end

  // A saturated beat always carries one of the two limit values.
  a_sat_limits: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (rate == RATE_MAX) || (rate == '0))
    else $error("saturated beat with a rate that is not a limit value");

  // The divider remainder stays below the divisor for every real division.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dv[DIV_STEPS] && !dstage[DIV_STEPS].byp |->
      dstage[DIV_STEPS].rem < dstage[DIV_STEPS].den)
    else $error("divider remainder not below divisor");

  // Reset leaves no beat on the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present straight after reset");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import igroc_pkg::*;

  localparam int BREAKPOINTS = BREAKPOINTS_DEFAULT;
  localparam int LATENCY     = 36;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 325;

  // One expected result beat.
  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              sat;
  } rate_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [TABLE_W-1:0]         cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [SPEED_W-1:0]         engine_speed = '0;
  logic [SPEED_W-1:0]         earlier_speed = '0;
  logic [SPEED_W-1:0]         later_speed = '0;
  logic signed [NORM_W-1:0]   normaliser = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [RATE_W-1:0]          rate;
  logic                       saturated;

  // Testbench copy of the gain table, updated when a write is accepted.
  logic [TABLE_W-1:0]         gain_shadow = GAIN_RESET;
  rate_result_t               rate_expected_q[$];
  int                         error_count = 0;
  int                         cycle_count = 0;
  bit                         sender_idle_en = 1'b0;
  bit                         receiver_idle_en = 1'b0;
  int                         stall_left = 0;

  interp_gain_rate_of_change #(
    .BREAKPOINTS(BREAKPOINTS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .engine_speed (engine_speed),
    .earlier_speed(earlier_speed),
    .later_speed  (later_speed),
    .normaliser   (normaliser),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rate         (rate),
    .saturated    (saturated)
  );

  always #5 clk = ~clk;

  // Interpolated gain in tenths, Q8.8; entries above the register read as zero.
  function automatic longint interp_gain_q8(input logic [TABLE_W-1:0] tbl,
                                            input logic [SPEED_W-1:0] axis);
    logic [63:0] ext;
    int unsigned whole;
    int          frac;
    int          lo;
    int          hi;
    ext   = {16'h0000, tbl};
    whole = 32'(axis >> 8);
    frac  = int'(axis[7:0]);
    if (whole < 1) begin
      return longint'(ext[7:0]) * 256;
    end
    if (whole >= BREAKPOINTS) begin
      return longint'(ext[(BREAKPOINTS-1)*8 +: 8]) * 256;
    end
    lo = int'(ext[(whole-1)*8 +: 8]);
    hi = int'(ext[whole*8 +: 8]);
    return longint'(lo * 256 + frac * (hi - lo));
  endfunction

  // Expected rate and saturation flag for one input beat.
  function automatic rate_result_t compute_rate(input logic [TABLE_W-1:0] tbl,
                                                input logic [SPEED_W-1:0] axis,
                                                input logic [SPEED_W-1:0] early,
                                                input logic [SPEED_W-1:0] late,
                                                input logic [NORM_W-1:0] norm);
    rate_result_t       res;
    longint             gain;
    longint             diff;
    longint             num;
    longint unsigned    num_mag;
    longint unsigned    den_mag;
    longint unsigned    quot;
    bit                 num_neg;
    bit                 den_neg;
    gain    = interp_gain_q8(tbl, axis);
    diff    = $signed({40'd0, late}) - $signed({40'd0, early});
    num     = gain * diff;
    num_neg = num < 0;
    num_mag = num_neg ? -num : num;
    den_neg = norm[NORM_W-1];
    den_mag = den_neg ? {32'd0, (~norm + 32'd1)} : {32'd0, norm};
    res     = '0;
    if (den_mag == 0) begin
      // A zero divisor saturates upwards only for a positive numerator.
      res.sat  = 1'b1;
      res.rate = (num_mag != 0 && !num_neg) ? RATE_MAX : '0;
    end else if (num_mag != 0 && num_neg == den_neg) begin
      quot = (num_mag << 16) / (den_mag * 10);
      if (quot > 64'hFFFF_FFFF) begin
        res.rate = RATE_MAX;
        res.sat  = 1'b1;
      end else begin
        res.rate = quot[RATE_W-1:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Sends one beat, with an optional idle burst first, and records its expected result.
  task automatic send_speed_item(input logic [SPEED_W-1:0] axis,
                                 input logic [SPEED_W-1:0] early,
                                 input logic [SPEED_W-1:0] late,
                                 input logic [NORM_W-1:0] norm);
    int gap;
    if (sender_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    engine_speed  <= axis;
    earlier_speed <= early;
    later_speed   <= late;
    normaliser    <= norm;
    do begin
      @(posedge clk);
    end while (in_stall);
    rate_expected_q.push_back(compute_rate(gain_shadow, axis, early, late, norm));
  endtask

  // Lowers valid and waits until every expected result has arrived.
  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (rate_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_gain_table(input logic [TABLE_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    gain_shadow = value;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic logic [SPEED_W-1:0] rand_axis();
    if ($urandom_range(0, 9) < 7) begin
      return SPEED_W'($urandom_range(0, 32'h0000_07FF));
    end
    return SPEED_W'($urandom());
  endfunction

  function automatic logic [NORM_W-1:0] rand_normaliser();
    logic [NORM_W-1:0] mag;
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0001;
      5, 6, 7, 8, 9, 10, 11: begin
        mag = $urandom_range(1, 32'h000F_FFFF);
        return $urandom_range(0, 1) ? -mag : mag;
      end
      default: return $urandom();
    endcase
  endfunction

  // Directed corners under the reset table, where every entry gives a gain of 2.5.
  task automatic test_reset_table_corners();
    send_speed_item(24'h000000, 24'h000000, 24'h000000, 32'h0001_0000);
    send_speed_item(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 32'h7FFF_FFFF);
    send_speed_item(24'h000100, 24'hFFFFFF, 24'h000000, 32'h8000_0000);
    send_speed_item(24'h000280, 24'h000100, 24'h000200, 32'h0000_0000);
    send_speed_item(24'h000280, 24'h000200, 24'h000100, 32'h0000_0000);
    send_speed_item(24'h000300, 24'h001234, 24'h001234, 32'h0000_0000);
    send_speed_item(24'h000300, 24'h000000, 24'h001000, 32'hFFFF_0000);
    send_speed_item(24'h000400, 24'h000000, 24'hFFFFFF, 32'h0000_0001);
    send_speed_item(24'h000500, 24'hFFFFFF, 24'h000000, 32'hFFFF_FFFF);
    send_speed_item(24'h000200, 24'h000000, 24'h000A00, 32'h0001_0000);
  endtask

  // Axis values across the table, with rising, falling and flat segments.
  task automatic test_table_interpolation();
    logic [SPEED_W-1:0] axis_pts[10];
    axis_pts = '{24'h000000, 24'h0000FF, 24'h000100, 24'h000180, 24'h0001FF,
                 24'h000380, 24'h000480, 24'h0005FF, 24'h000600, 24'hFFFFFF};
    write_gain_table(48'hFF00_C864_320A);
    foreach (axis_pts[i]) begin
      send_speed_item(axis_pts[i], 24'h000000, 24'h001000, 32'h0001_0000);
    end
  endtask

  // Random beats over several table settings, with idling switched per stretch.
  task automatic test_random_items();
    logic [TABLE_W-1:0] tables[6];
    logic [SPEED_W-1:0] early;
    logic [SPEED_W-1:0] late;
    tables = '{TABLE_W'({$urandom(), $urandom()}), 48'h0, 48'hFFFF_FFFF_FFFF,
               TABLE_W'({$urandom(), $urandom()}), GAIN_RESET,
               TABLE_W'({$urandom(), $urandom()})};
    foreach (tables[p]) begin
      write_gain_table(tables[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) begin
          sender_idle_en   = (p != 5) && ($urandom_range(0, 3) != 0);
          receiver_idle_en = (p != 5) && ($urandom_range(0, 3) != 0);
        end
        early = SPEED_W'($urandom());
        if ($urandom_range(0, 1)) begin
          late = SPEED_W'(32'(early) + $urandom_range(0, 32'h0000_0FFF) - 32'h0000_0800);
        end else begin
          late = SPEED_W'($urandom());
        end
        send_speed_item(rand_axis(), early, late, rand_normaliser());
      end
    end
  endtask

  // Receiver stall bursts, changed at the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (receiver_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = int'($urandom_range(1, 13)) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    rate_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (rate_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat rate=%h saturated=%b",
                                  rate, saturated));
      end else begin
        want = rate_expected_q.pop_front();
        if (rate !== want.rate) begin
          report_mismatch($sformatf("rate got %h, expected %h", rate, want.rate));
        end
        if (saturated !== want.sat) begin
          report_mismatch($sformatf("saturated got %b, expected %b", saturated, want.sat));
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_reset_table_corners();
    test_table_interpolation();
    test_random_items();
    drain_results();
    repeat (LATENCY + 4) @(posedge clk);
    if (error_count == 0 && rate_expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/igroc_pkg.sv
hw/rtl/interp_gain_rate_of_change.sv
tb/sv/tb_top.sv
